// File: rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps
// lkvc_pkg: shared constants, request/result, entry and scan control/result types of the lru key-value cache
// no dependencies

package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int STAMP_BITS = 32;
    localparam int LEN_W      = 3;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int LEN_LIM = ((VALUE_BITS / 8) > 7) ? 7 : (VALUE_BITS / 8);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LEN_LIM);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [1:0] KIND_SET = 2'd0;
    localparam logic [1:0] KIND_GET = 2'd1;
    localparam logic [1:0] KIND_DEL = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [LEN_W-1:0]      value_len;
    } t_req;

    typedef struct packed {
        logic                  status;
        logic [VALUE_BITS-1:0] read_value;
        logic [LEN_W-1:0]      read_len;
    } t_rsp;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [LEN_W-1:0]      len;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             valid;
    } t_scan_ctl;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        t_entry           hit_word;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] vic_idx;
    } t_scan_res;

endpackage

// File: rtl/core/lkvc_ram.sv
`timescale 1ns / 1ps
// lkvc_ram: single-port-write, single-port-read synchronous ram with registered read data
// no dependencies

module lkvc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lkvc_scan.sv
`timescale 1ns / 1ps
// lkvc_scan: per-entry key match, first free slot and oldest-stamp victim tracking
// depends on lkvc_pkg

module lkvc_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkvc_pkg::t_scan_ctl               i_ctl,
    input  lkvc_pkg::t_entry                  i_word,
    input  logic [lkvc_pkg::KEY_BITS-1:0]     i_key,
    input  logic [lkvc_pkg::STAMP_BITS-1:0]   i_counter,
    output lkvc_pkg::t_scan_res               o_res
);

    import lkvc_pkg::*;

    t_scan_res             r_res;
    logic                  r_vic_found;
    logic [STAMP_BITS-1:0] r_vic_age;
    logic [STAMP_BITS-1:0] w_age;

    // modular age keeps order across a counter wrap
    assign w_age = i_counter - i_word.stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.hit        <= 1'b0;
            r_res.free_found <= 1'b0;
            r_vic_found      <= 1'b0;
        end else if (i_ctl.clear) begin
            r_res.hit        <= 1'b0;
            r_res.free_found <= 1'b0;
            r_vic_found      <= 1'b0;
        end else if (i_ctl.vld) begin
            if (i_ctl.valid) begin
                if (!r_res.hit && i_word.key == i_key) begin
                    r_res.hit      <= 1'b1;
                    r_res.hit_idx  <= i_ctl.idx;
                    r_res.hit_word <= i_word;
                end
                if (!r_vic_found || w_age > r_vic_age) begin
                    r_vic_found   <= 1'b1;
                    r_vic_age     <= w_age;
                    r_res.vic_idx <= i_ctl.idx;
                end
            end else if (!r_res.free_found) begin
                r_res.free_found <= 1'b1;
                r_res.free_idx   <= i_ctl.idx;
            end
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// lru_key_value_cache_core: top level, request sequencer, valid bits, count and use counter
// depends on lkvc_pkg, lkvc_ram, lkvc_scan
// o_done pulses once the request has passed S_SCAN, S_DRAIN and S_WRITE; it is registered from S_WRITE
// a new request is accepted only in S_IDLE; each request scans the 16 entries through the
//   single ram read port, then drains the read data and writes back before returning to idle
// reset: synchronous, clears valid bits, count, use counter and control, and sets capacity to 16
// o_done is a one-cycle strobe; the receiver cannot stall

module lru_key_value_cache_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lkvc_pkg::t_req         i_req,
    output logic                   o_done,
    output lkvc_pkg::t_rsp         o_rsp,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_data
);

    import lkvc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [ENTRIES-1:0]    r_valid;
    logic [CNT_W-1:0]      r_count;
    logic [STAMP_BITS-1:0] r_counter;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_done;
    t_rsp                  r_rsp, n_rsp;

    logic [$bits(t_entry)-1:0] w_rd_data;
    t_entry                    w_rd_word;
    t_entry                    w_wdata;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    t_scan_ctl                 w_ctl;
    t_scan_res                 w_res;
    logic [CMP_W-1:0]          w_cap_ext;
    logic [CMP_W-1:0]          w_eff_cap;
    logic                      w_evict;
    logic [IDX_W-1:0]          w_ins_idx;
    logic [LEN_W-1:0]          w_len;

    assign w_rd_word = t_entry'(w_rd_data);

    // effective capacity: zero acts as one, above ENTRIES acts as ENTRIES
    always_comb begin
        w_cap_ext = CMP_W'(r_cap);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    assign w_evict   = (CMP_W'(r_count) >= w_eff_cap);
    // victim slot frees up, so the insert takes the lower of it and the first free slot
    assign w_ins_idx = (w_evict && (!w_res.free_found || w_res.vic_idx < w_res.free_idx))
                       ? w_res.vic_idx : w_res.free_idx;
    assign w_len     = (i_req.value_len > LEN_MAX) ? LEN_MAX : i_req.value_len;

    always_comb begin
        n_req           = i_req;
        n_req.value_len = w_len;
    end

    assign w_ctl.clear = (r_state == S_IDLE) && start;
    assign w_ctl.vld   = r_rd_vld;
    assign w_ctl.idx   = r_rd_idx;
    assign w_ctl.valid = r_valid[r_rd_idx];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_res.hit_idx;
        w_wdata = w_res.hit_word;
        if (r_state == S_WRITE) begin
            case (r_req.kind)
                KIND_SET: begin
                    w_we          = 1'b1;
                    w_waddr       = w_res.hit ? w_res.hit_idx : w_ins_idx;
                    w_wdata.key   = r_req.key;
                    w_wdata.value = r_req.value;
                    w_wdata.len   = r_req.value_len;
                    w_wdata.stamp = r_counter;
                end
                KIND_GET: begin
                    w_we          = w_res.hit;
                    w_wdata.stamp = r_counter;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_rsp = '0;
        case (r_req.kind)
            KIND_GET: begin
                if (w_res.hit) begin
                    n_rsp.read_value = w_res.hit_word.value;
                    n_rsp.read_len   = w_res.hit_word.len;
                end else begin
                    n_rsp.status = 1'b1;
                end
            end
            KIND_DEL: begin
                n_rsp.status = !w_res.hit;
            end
            default: begin
                n_rsp.status = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_SCAN;
            S_SCAN:  if (r_addr == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN: n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    lkvc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_addr),
        .o_rdata (w_rd_data)
    );

    lkvc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_word    (w_rd_word),
        .i_key     (r_req.key),
        .i_counter (r_counter),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_counter <= '0;
            r_cap     <= CAP_RESET;
            r_done    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            r_done   <= (r_state == S_WRITE);
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == S_WRITE) begin
                case (r_req.kind)
                    KIND_SET: begin
                        r_counter <= r_counter + 1'b1;
                        if (!w_res.hit) begin
                            if (w_evict) begin
                                r_valid <= (r_valid & ~(ENTRIES'(1) << w_res.vic_idx))
                                           | (ENTRIES'(1) << w_ins_idx);
                            end else begin
                                r_valid[w_ins_idx] <= 1'b1;
                                r_count            <= r_count + 1'b1;
                            end
                        end
                    end
                    KIND_GET: begin
                        if (w_res.hit) begin
                            r_counter <= r_counter + 1'b1;
                        end
                    end
                    KIND_DEL: begin
                        if (w_res.hit) begin
                            r_valid[w_res.hit_idx] <= 1'b0;
                            if (r_count != '0) begin
                                r_count <= r_count - 1'b1;
                            end
                        end
                    end
                    default: begin
                        r_counter <= r_counter;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= n_req;
        end
        if (r_state == S_IDLE) begin
            r_addr <= '0;
        end else if (r_state == S_SCAN && r_addr != LAST_IDX) begin
            r_addr <= r_addr + 1'b1;
        end
        r_rd_idx <= r_addr;
        if (r_state == S_WRITE) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/core/lkvc_checker.sv
`timescale 1ns / 1ps
// lkvc_checker: port-level assertions for the lru key-value cache, bound to the top level
// depends on lkvc_pkg and lru_key_value_cache_core

module lkvc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input lkvc_pkg::t_rsp   o_rsp
);

    import lkvc_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without a result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status |-> o_rsp.read_value == '0 && o_rsp.read_len == '0)
        else $error("missing status with nonzero data");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
